// ----- rtl/core/lrpe_pkg.sv -----
// Shared types and constants for the link probe engine.
// No dependencies; every other file in rtl/core imports this package.
package lrpe_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_RX    = 2'd1,
      ACT_TXDONE = 2'd2,
      ACT_TICK  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      SEND_NONE  = 2'd0,
      SEND_PROBE = 2'd1,
      SEND_ECHO  = 2'd2
   } send_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEST_ADDRESS    = 3'd0,
      CSR_PAYLOAD_LENGTH  = 3'd1,
      CSR_TIMEOUT_TICKS   = 3'd2,
      CSR_PROBE_KIND_CODE = 3'd3,
      CSR_REPLY_KIND_CODE = 3'd4
   } csr_index_type;

   localparam logic [15:0] DEST_ADDRESS_RST    = 16'hFFFF;
   localparam logic [6:0]  PAYLOAD_LENGTH_RST  = 7'd0;
   localparam logic [15:0] TIMEOUT_TICKS_RST   = 16'd1000;
   localparam logic [7:0]  PROBE_KIND_CODE_RST = 8'd0;
   localparam logic [7:0]  REPLY_KIND_CODE_RST = 8'd1;

   typedef struct packed {
      logic [15:0] dest_address;
      logic [6:0]  payload_length;
      logic [15:0] timeout_ticks;
      logic [7:0]  probe_kind_code;
      logic [7:0]  reply_kind_code;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] start_count;
      logic [7:0]  rx_kind;
      logic [15:0] rx_seq;
      logic [15:0] rx_source;
      logic [6:0]  rx_length;
      logic        tx_ok;
   } req_type;

   typedef struct packed {
      logic [1:0]  send_kind;
      logic [15:0] send_dest;
      logic [15:0] send_seq;
      logic [6:0]  send_length;
      logic        finished;
      logic [15:0] remaining;
      logic [15:0] sent_count;
      logic [15:0] recv_count;
      logic [15:0] failed_count;
      logic [15:0] timeout_count;
      logic [31:0] elapsed_ticks;
   } rsp_type;

   typedef struct packed {
      logic [15:0] outstanding;
      logic [15:0] timer_left;
      logic        timer_armed;
      logic [15:0] probes_sent;
      logic [15:0] frames_received;
      logic [15:0] send_failures;
      logic [15:0] reply_timeouts;
      logic        run_done;
      logic [31:0] run_ticks;
   } run_state_type;

endpackage

// ----- rtl/core/lrpe_req_if.sv -----
// Event channel into the probe engine: valid/ready plus one event's fields.
// Depends on lrpe_pkg.
interface lrpe_req_if
   import lrpe_pkg::*;
();
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] start_count;
   logic [7:0]  rx_kind;
   logic [15:0] rx_seq;
   logic [15:0] rx_source;
   logic [6:0]  rx_length;
   logic        tx_ok;

   modport source (
      output valid, action, start_count, rx_kind, rx_seq, rx_source, rx_length, tx_ok,
      input  ready
   );
   modport sink (
      input  valid, action, start_count, rx_kind, rx_seq, rx_source, rx_length, tx_ok,
      output ready
   );
endinterface

// ----- rtl/core/lrpe_rsp_if.sv -----
// Result channel out of the probe engine: valid/ready plus frame and counters.
// Depends on lrpe_pkg.
interface lrpe_rsp_if
   import lrpe_pkg::*;
();
   logic        valid;
   logic        ready;
   logic [1:0]  send_kind;
   logic [15:0] send_dest;
   logic [15:0] send_seq;
   logic [6:0]  send_length;
   logic        finished;
   logic [15:0] remaining;
   logic [15:0] sent_count;
   logic [15:0] recv_count;
   logic [15:0] failed_count;
   logic [15:0] timeout_count;
   logic [31:0] elapsed_ticks;

   modport source (
      output valid, send_kind, send_dest, send_seq, send_length, finished, remaining,
             sent_count, recv_count, failed_count, timeout_count, elapsed_ticks,
      input  ready
   );
   modport sink (
      input  valid, send_kind, send_dest, send_seq, send_length, finished, remaining,
             sent_count, recv_count, failed_count, timeout_count, elapsed_ticks,
      output ready
   );
endinterface

// ----- rtl/core/lrpe_step.sv -----
// Next-state and result logic for one event of the probe engine.
// Purely combinational; depends on lrpe_pkg.
module lrpe_step
   import lrpe_pkg::*;
(
   input  cfg_type       cfg,
   input  run_state_type cur,
   input  req_type       item,
   output run_state_type nxt,
   output rsp_type       rsp
);

   run_state_type pre;
   rsp_type       rsp_base;
   logic          advance;
   logic          probe_on_advance;
   logic [15:0]   out_dec;
   logic [15:0]   arm_value;

   assign arm_value        = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
   assign out_dec          = pre.outstanding - 16'd1;
   assign probe_on_advance = advance && (out_dec != 16'd0);

   always_comb begin
      pre = cur;
      advance = 1'b0;
      rsp_base = '0;
      rsp_base.send_kind = SEND_NONE;
      case (action_type'(item.action))
         ACT_START: begin
            if (cur.outstanding == 16'd0 && item.start_count != 16'd0) begin
               pre.run_done        = 1'b0;
               pre.frames_received = 16'd0;
               pre.send_failures   = 16'd0;
               pre.reply_timeouts  = 16'd0;
               pre.run_ticks       = 32'd0;
               pre.outstanding     = item.start_count;
               pre.probes_sent     = 16'd1;
               pre.timer_left      = arm_value;
               pre.timer_armed     = 1'b1;
               rsp_base.send_kind   = SEND_PROBE;
               rsp_base.send_dest   = cfg.dest_address;
               rsp_base.send_seq    = item.start_count;
               rsp_base.send_length = cfg.payload_length;
            end
         end
         ACT_RX: begin
            if (item.rx_kind == cfg.reply_kind_code && cur.outstanding != 16'd0 &&
                item.rx_seq == cur.outstanding) begin
               pre.frames_received = cur.frames_received + 16'd1;
               advance = 1'b1;
            end else if (item.rx_kind == cfg.probe_kind_code) begin
               pre.frames_received = cur.frames_received + 16'd1;
               rsp_base.send_kind   = SEND_ECHO;
               rsp_base.send_dest   = item.rx_source;
               rsp_base.send_seq    = item.rx_seq;
               rsp_base.send_length = item.rx_length;
            end
         end
         ACT_TXDONE: begin
            if (!item.tx_ok) begin
               pre.send_failures = cur.send_failures + 16'd1;
            end
         end
         ACT_TICK: begin
            if (cur.outstanding != 16'd0) begin
               pre.run_ticks = cur.run_ticks + 32'd1;
               if (cur.timer_armed) begin
                  if (cur.timer_left > 16'd1) begin
                     pre.timer_left = cur.timer_left - 16'd1;
                  end else begin
                     pre.timer_left     = 16'd0;
                     pre.timer_armed    = 1'b0;
                     pre.reply_timeouts = cur.reply_timeouts + 16'd1;
                     advance = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Probe answered or timed out: re-probe, or close the run.
   always_comb begin
      nxt = pre;
      if (advance) begin
         nxt.outstanding = out_dec;
         if (out_dec != 16'd0) begin
            nxt.probes_sent = pre.probes_sent + 16'd1;
            nxt.timer_left  = arm_value;
            nxt.timer_armed = 1'b1;
         end else begin
            nxt.timer_armed = 1'b0;
            nxt.timer_left  = 16'd0;
            nxt.run_done    = 1'b1;
         end
      end
   end

   always_comb begin
      rsp = rsp_base;
      if (probe_on_advance) begin
         rsp.send_kind   = SEND_PROBE;
         rsp.send_dest   = cfg.dest_address;
         rsp.send_seq    = out_dec;
         rsp.send_length = cfg.payload_length;
      end
      rsp.finished      = nxt.run_done;
      rsp.remaining     = nxt.outstanding;
      rsp.sent_count    = nxt.probes_sent;
      rsp.recv_count    = nxt.frames_received;
      rsp.failed_count  = nxt.send_failures;
      rsp.timeout_count = nxt.reply_timeouts;
      rsp.elapsed_ticks = nxt.run_done ? nxt.run_ticks : 32'd0;
   end

endmodule

// ----- rtl/core/link_rtt_probe_engine.sv -----
// Link-test probe engine: top level with event register, result register and CSRs.
// Each accepted event passes the event register, then the result register, to rsp.
// Throughput: one event per cycle unless rsp stalls, set by the lrpe_step update.
// Reset: synchronous, active high; clears run state, pipeline valids and loads
// the CSR defaults. Depends on lrpe_pkg, lrpe_req_if, lrpe_rsp_if, lrpe_step.
module link_rtt_probe_engine
   import lrpe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   lrpe_req_if.sink               req_chan,
   lrpe_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // CSRs: user must write only while the engine is quiet; block does not enforce it.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEST_ADDRESS:    cfg_in.dest_address    = csr_wdata;
            CSR_PAYLOAD_LENGTH:  cfg_in.payload_length  = csr_wdata[6:0];
            CSR_TIMEOUT_TICKS:   cfg_in.timeout_ticks   = csr_wdata;
            CSR_PROBE_KIND_CODE: cfg_in.probe_kind_code = csr_wdata[7:0];
            CSR_REPLY_KIND_CODE: cfg_in.reply_kind_code = csr_wdata[7:0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_address    <= DEST_ADDRESS_RST;
         cfg_ff.payload_length  <= PAYLOAD_LENGTH_RST;
         cfg_ff.timeout_ticks   <= TIMEOUT_TICKS_RST;
         cfg_ff.probe_kind_code <= PROBE_KIND_CODE_RST;
         cfg_ff.reply_kind_code <= REPLY_KIND_CODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Stage 1: registered event. Stage 2: registered result.
   logic          ev_vld_ff, ev_vld_in;
   req_type       ev_ff, ev_in;
   logic          res_vld_ff, res_vld_in;
   rsp_type       res_ff, res_in;
   run_state_type state_ff, state_in;
   run_state_type state_nxt;
   rsp_type       step_rsp;
   logic          advance;
   logic          req_take;

   // Move the event into the result register when that slot is free or draining.
   assign advance  = ev_vld_ff && (!res_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !ev_vld_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      ev_in.action      = req_chan.action;
      ev_in.start_count = req_chan.start_count;
      ev_in.rx_kind     = req_chan.rx_kind;
      ev_in.rx_seq      = req_chan.rx_seq;
      ev_in.rx_source   = req_chan.rx_source;
      ev_in.rx_length   = req_chan.rx_length;
      ev_in.tx_ok       = req_chan.tx_ok;
   end

   assign ev_vld_in = req_take ? 1'b1 : (advance ? 1'b0 : ev_vld_ff);

   lrpe_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (ev_ff),
      .nxt  (state_nxt),
      .rsp  (step_rsp)
   );

   // Commit the run state only when the event actually retires into stage 2.
   assign state_in   = advance ? state_nxt : state_ff;
   assign res_in     = advance ? step_rsp : res_ff;
   assign res_vld_in = advance ? 1'b1 : ((res_vld_ff && rsp_chan.ready) ? 1'b0 : res_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_vld_ff  <= 1'b0;
         res_vld_ff <= 1'b0;
         state_ff   <= '0;
      end else begin
         ev_vld_ff  <= ev_vld_in;
         res_vld_ff <= res_vld_in;
         state_ff   <= state_in;
      end
   end

   // Payload registers; hold while stalled.
   always_ff @(posedge clock) begin
      if (req_take) begin
         ev_ff <= ev_in;
      end
      res_ff <= res_in;
   end

   assign rsp_chan.valid         = res_vld_ff;
   assign rsp_chan.send_kind     = res_ff.send_kind;
   assign rsp_chan.send_dest     = res_ff.send_dest;
   assign rsp_chan.send_seq      = res_ff.send_seq;
   assign rsp_chan.send_length   = res_ff.send_length;
   assign rsp_chan.finished      = res_ff.finished;
   assign rsp_chan.remaining     = res_ff.remaining;
   assign rsp_chan.sent_count    = res_ff.sent_count;
   assign rsp_chan.recv_count    = res_ff.recv_count;
   assign rsp_chan.failed_count  = res_ff.failed_count;
   assign rsp_chan.timeout_count = res_ff.timeout_count;
   assign rsp_chan.elapsed_ticks = res_ff.elapsed_ticks;

   // An armed timer only exists inside an open run.
   a_armed_in_run: assert property (@(posedge clock) disable iff (reset)
      state_ff.timer_armed |-> (state_ff.outstanding != 16'd0))
      else $error("timer armed with no outstanding probes");

   // A finished run has nothing left outstanding.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff.run_done |-> (state_ff.outstanding == 16'd0))
      else $error("run_done set while probes remain");

   // A held event must not be lost while the result slot is blocked.
   a_event_held: assert property (@(posedge clock) disable iff (reset)
      (ev_vld_ff && !advance) |=> (ev_vld_ff && $stable(ev_ff)))
      else $error("stalled event dropped or changed");

endmodule

// ----- tb/link_rtt_probe_engine_test.sv -----
// Self-checking testbench for link_rtt_probe_engine: directed probe runs, then random event
// traffic under several register settings, every result checked against a run-state predictor.
// Depends on lrpe_pkg, lrpe_req_if, lrpe_rsp_if and the engine RTL.
module link_rtt_probe_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lrpe_pkg::*;

   localparam int unsigned HALF_PERIOD   = 4;
   localparam int unsigned RESET_CYCLES  = 8;
   // Covers the event and result registers of the pipeline, plus margin.
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned DRAIN_LIMIT   = 5000;
   localparam int unsigned CSR_COUNT     = 5;
   localparam int unsigned RANDOM_PHASES = 4;
   localparam int unsigned PHASE_EVENTS  = 210;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   lrpe_req_if req ();
   lrpe_rsp_if rsp ();

   link_rtt_probe_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted register contents and run state, kept in step with every transfer.
   cfg_type       engine_cfg;
   run_state_type engine_state;
   // Results predicted for accepted events, oldest first.
   rsp_type       pending_results[$];
   int unsigned   error_count = 0;
   // Random idling on the event side and stalling on the result side.
   bit            sender_gaps = 1'b1;
   bit            receiver_stalls = 1'b1;

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   // Emit the next probe of the open run and re-arm the reply timer.
   function automatic void launch_probe(inout rsp_type res);
      engine_state.probes_sent += 16'd1;
      res.send_kind   = SEND_PROBE;
      res.send_dest   = engine_cfg.dest_address;
      res.send_seq    = engine_state.outstanding;
      res.send_length = engine_cfg.payload_length;
      // A zero timeout register behaves as one tick.
      engine_state.timer_left  = (engine_cfg.timeout_ticks != 16'd0) ?
                                 engine_cfg.timeout_ticks : 16'd1;
      engine_state.timer_armed = 1'b1;
   endfunction

   // Retire the current probe (answered or timed out): probe again or close the run.
   function automatic void retire_probe(inout rsp_type res);
      engine_state.outstanding -= 16'd1;
      if (engine_state.outstanding != 16'd0) begin
         launch_probe(res);
      end else begin
         engine_state.timer_armed = 1'b0;
         engine_state.timer_left  = 16'd0;
         engine_state.run_done    = 1'b1;
      end
   endfunction

   // Apply one event to the predicted state and return the result it must produce.
   function automatic rsp_type predict_result(input req_type ev);
      rsp_type res;
      res = '0;
      case (ev.action)
         ACT_START: begin
            // A start during an open run, or with a zero count, does nothing.
            if (engine_state.outstanding == 16'd0 && ev.start_count != 16'd0) begin
               engine_state.run_done        = 1'b0;
               engine_state.probes_sent     = '0;
               engine_state.frames_received = '0;
               engine_state.send_failures   = '0;
               engine_state.reply_timeouts  = '0;
               engine_state.run_ticks       = '0;
               engine_state.outstanding     = ev.start_count;
               launch_probe(res);
            end
         end
         ACT_RX: begin
            // A reply matches only during a run and only with the current sequence word;
            // anything else carrying the probe code is echoed back to its source.
            if (ev.rx_kind == engine_cfg.reply_kind_code && engine_state.outstanding != 16'd0
                && ev.rx_seq == engine_state.outstanding) begin
               engine_state.frames_received += 16'd1;
               retire_probe(res);
            end else if (ev.rx_kind == engine_cfg.probe_kind_code) begin
               engine_state.frames_received += 16'd1;
               res.send_kind   = SEND_ECHO;
               res.send_dest   = ev.rx_source;
               res.send_seq    = ev.rx_seq;
               res.send_length = ev.rx_length;
            end
         end
         ACT_TXDONE: begin
            if (!ev.tx_ok) engine_state.send_failures += 16'd1;
         end
         ACT_TICK: begin
            // Ticks count only while a run is open.
            if (engine_state.outstanding != 16'd0) begin
               engine_state.run_ticks += 32'd1;
               if (engine_state.timer_armed) begin
                  if (engine_state.timer_left > 16'd1) begin
                     engine_state.timer_left -= 16'd1;
                  end else begin
                     engine_state.timer_left     = 16'd0;
                     engine_state.timer_armed    = 1'b0;
                     engine_state.reply_timeouts += 16'd1;
                     retire_probe(res);
                  end
               end
            end
         end
         default: ;
      endcase
      res.finished      = engine_state.run_done;
      res.remaining     = engine_state.outstanding;
      res.sent_count    = engine_state.probes_sent;
      res.recv_count    = engine_state.frames_received;
      res.failed_count  = engine_state.send_failures;
      res.timeout_count = engine_state.reply_timeouts;
      // Elapsed time reads zero until the run has finished.
      res.elapsed_ticks = engine_state.run_done ? engine_state.run_ticks : 32'd0;
      return res;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------------

   // Print one line per mismatch and count every one.
   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   task automatic compare_result(input rsp_type want);
      check_field("send_kind",     32'(rsp.send_kind),     32'(want.send_kind));
      check_field("send_dest",     32'(rsp.send_dest),     32'(want.send_dest));
      check_field("send_seq",      32'(rsp.send_seq),      32'(want.send_seq));
      check_field("send_length",   32'(rsp.send_length),   32'(want.send_length));
      check_field("finished",      32'(rsp.finished),      32'(want.finished));
      check_field("remaining",     32'(rsp.remaining),     32'(want.remaining));
      check_field("sent_count",    32'(rsp.sent_count),    32'(want.sent_count));
      check_field("recv_count",    32'(rsp.recv_count),    32'(want.recv_count));
      check_field("failed_count",  32'(rsp.failed_count),  32'(want.failed_count));
      check_field("timeout_count", 32'(rsp.timeout_count), 32'(want.timeout_count));
      check_field("elapsed_ticks", rsp.elapsed_ticks,      want.elapsed_ticks);
   endtask

   // Check every result transfer against the oldest prediction. Values read here are the
   // pre-edge values, since all inputs are driven with nonblocking assignments.
   always @(posedge clock) begin
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         if (pending_results.size() == 0) report_mismatch("result with nothing expected");
         else compare_result(pending_results.pop_front());
      end
   end

   // Result-side ready: stall in random-length bursts while stalls are enabled.
   initial begin : result_receiver
      int unsigned hold;
      hold = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold != 0) begin
            hold--;
            rsp.ready <= 1'b0;
         end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(0, 4);
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------

   function automatic req_type event_of(input action_type act,
                                        input logic [15:0] count  = '0,
                                        input logic [7:0]  kind   = '0,
                                        input logic [15:0] seq    = '0,
                                        input logic [15:0] source = '0,
                                        input logic [6:0]  len    = '0,
                                        input logic        ok     = 1'b0);
      req_type ev;
      ev.action      = act;
      ev.start_count = count;
      ev.rx_kind     = kind;
      ev.rx_seq      = seq;
      ev.rx_source   = source;
      ev.rx_length   = len;
      ev.tx_ok       = ok;
      return ev;
   endfunction

   // Drive one event and hold it until the transfer; record its predicted result.
   // Valid is left high after the transfer so back-to-back events need no second assignment
   // in the same step; a gap or settle() drops it.
   task automatic send_event(input req_type ev);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.action      <= ev.action;
      req.start_count <= ev.start_count;
      req.rx_kind     <= ev.rx_kind;
      req.rx_seq      <= ev.rx_seq;
      req.rx_source   <= ev.rx_source;
      req.rx_length   <= ev.rx_length;
      req.tx_ok       <= ev.tx_ok;
      do @(posedge clock); while (req.ready !== 1'b1);
      pending_results.push_back(predict_result(ev));
   endtask

   // Drop valid, wait for every outstanding result, then let the pipeline empty.
   task automatic settle();
      int unsigned waited;
      waited = 0;
      req.valid <= 1'b0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; the write takes effect at the next edge. The caller drops csr_we.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_DEST_ADDRESS:    engine_cfg.dest_address    = value;
         CSR_PAYLOAD_LENGTH:  engine_cfg.payload_length  = value[6:0];
         CSR_TIMEOUT_TICKS:   engine_cfg.timeout_ticks   = value;
         CSR_PROBE_KIND_CODE: engine_cfg.probe_kind_code = value[7:0];
         CSR_REPLY_KIND_CODE: engine_cfg.reply_kind_code = value[7:0];
         default: ;
      endcase
   endtask

   // Reprogram every register once the engine is idle. Set junk in the unused upper data
   // bits, and hit an unused index as well: neither may disturb anything.
   task automatic program_engine(input cfg_type c);
      logic [15:0] junk;
      junk = 16'($urandom);
      settle();
      write_register(CSR_DEST_ADDRESS,    c.dest_address);
      write_register(CSR_PAYLOAD_LENGTH,  {junk[15:7], c.payload_length});
      write_register(CSR_TIMEOUT_TICKS,   c.timeout_ticks);
      write_register(CSR_PROBE_KIND_CODE, {junk[7:0], c.probe_kind_code});
      write_register(CSR_REPLY_KIND_CODE, {junk[15:8], c.reply_kind_code});
      write_register(CSR_INDEX_W'($urandom_range(CSR_COUNT, 2 ** CSR_INDEX_W - 1)),
                     CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
   endtask

   // Pick zero, the top of the range, or anything in between.
   function automatic logic [15:0] choose_value(input logic [15:0] top);
      case ($urandom_range(0, 3))
         0:       return 16'd0;
         1:       return top;
         default: return 16'($urandom_range(0, top));
      endcase
   endfunction

   // Build an event that mostly keeps runs moving: short starts when idle, matching replies
   // and ticks during a run, mixed with echoes, stale replies, ignored starts and noise.
   function automatic req_type random_event();
      req_type     ev;
      int unsigned pick;
      ev.action      = 2'($urandom);
      ev.start_count = 16'($urandom);
      ev.rx_kind     = 8'($urandom);
      ev.rx_seq      = 16'($urandom);
      ev.rx_source   = 16'($urandom);
      ev.rx_length   = 7'($urandom);
      ev.tx_ok       = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (engine_state.outstanding == 16'd0) begin
         if (pick < 55) begin
            ev.action      = ACT_START;
            ev.start_count = (pick < 4)  ? 16'd0 :
                             (pick < 10) ? 16'($urandom_range(7, 40)) :
                                           16'($urandom_range(1, 6));
         end else begin
            // Keep idle noise off starts so no huge run gets opened.
            ev.action = action_type'($urandom_range(ACT_RX, ACT_TICK));
            if (pick < 65) ev.rx_kind = engine_cfg.probe_kind_code;
         end
      end else if (pick < 30) begin
         ev.action  = ACT_RX;
         ev.rx_kind = engine_cfg.reply_kind_code;
         ev.rx_seq  = engine_state.outstanding;
      end else if (pick < 55) begin
         ev.action = ACT_TICK;
      end else if (pick < 67) begin
         ev.action = ACT_TXDONE;
      end else if (pick < 76) begin
         ev.action  = ACT_RX;
         ev.rx_kind = engine_cfg.probe_kind_code;
      end else if (pick < 84) begin
         // Reply with a stale sequence word.
         ev.action  = ACT_RX;
         ev.rx_kind = engine_cfg.reply_kind_code;
         ev.rx_seq  = engine_state.outstanding + 16'($urandom_range(1, 3));
      end else if (pick < 90) begin
         ev.action = ACT_START;
      end
      return ev;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Events with no run open, under the reset register values.
   task automatic test_idle_events();
      send_event(event_of(ACT_TICK));
      // Reply code with no run open: ignored.
      send_event(event_of(ACT_RX, 16'd0, REPLY_KIND_CODE_RST, 16'd0, 16'h5A5A, 7'd3));
      // Incoming probe with all-ones fields: echo.
      send_event(event_of(ACT_RX, 16'hFFFF, PROBE_KIND_CODE_RST, 16'hFFFF, 16'hFFFF, 7'h7F));
      send_event(event_of(ACT_TXDONE, 16'd0, 8'd0, 16'd0, 16'd0, 7'd0, 1'b0));
      send_event(event_of(ACT_TXDONE, 16'd0, 8'd0, 16'd0, 16'd0, 7'd0, 1'b1));
      // Zero count: ignored.
      send_event(event_of(ACT_START, 16'd0));
   endtask

   // A two-probe run closed by replies, with an ignored start, a wrong-sequence reply and a tick in between.
   task automatic test_reply_driven_run();
      send_event(event_of(ACT_START, 16'd2));
      send_event(event_of(ACT_START, 16'hFFFF));
      send_event(event_of(ACT_RX, 16'd0, REPLY_KIND_CODE_RST, 16'd1));
      send_event(event_of(ACT_TICK));
      send_event(event_of(ACT_RX, 16'd0, REPLY_KIND_CODE_RST, 16'd2));
      send_event(event_of(ACT_RX, 16'd0, REPLY_KIND_CODE_RST, 16'd1));
   endtask

   // Zero timeout (one tick), equal probe and reply codes, extreme address and length.
   task automatic test_timeout_run();
      cfg_type c;
      c.dest_address    = 16'h0000;
      c.payload_length  = 7'h7F;
      c.timeout_ticks   = 16'd0;
      c.probe_kind_code = 8'hA5;
      c.reply_kind_code = 8'hA5;
      program_engine(c);
      send_event(event_of(ACT_START, 16'd3));
      send_event(event_of(ACT_TICK));
      send_event(event_of(ACT_RX, 16'd0, 8'hA5, 16'd2));
      // Wrong sequence with a code that is also the probe code: echo.
      send_event(event_of(ACT_RX, 16'd0, 8'hA5, 16'd7, 16'h1234, 7'd9));
      send_event(event_of(ACT_RX, 16'd0, 8'h5A, 16'd1));
      send_event(event_of(ACT_TICK));
      send_event(event_of(ACT_TICK));
      // New run clears the statistics of the finished one.
      send_event(event_of(ACT_START, 16'd1));
      send_event(event_of(ACT_TICK));
   endtask

   // Random traffic over several register settings; the last phase runs without idling.
   task automatic test_random_runs();
      cfg_type c;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         c.dest_address    = choose_value(16'hFFFF);
         c.payload_length  = 7'(choose_value(16'h007F));
         c.probe_kind_code = 8'(choose_value(16'h00FF));
         c.reply_kind_code = 8'(choose_value(16'h00FF));
         case (phase)
            1:       c.timeout_ticks = 16'hFFFF;
            2:       c.timeout_ticks = 16'd0;
            default: c.timeout_ticks = 16'($urandom_range(1, 8));
         endcase
         sender_gaps     = (phase != RANDOM_PHASES - 1);
         receiver_stalls = sender_gaps;
         program_engine(c);
         repeat (PHASE_EVENTS) send_event(random_event());
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      // Drive every input to a known value and hold reset.
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      req.valid       <= 1'b0;
      req.action      <= ACT_START;
      req.start_count <= '0;
      req.rx_kind     <= '0;
      req.rx_seq      <= '0;
      req.rx_source   <= '0;
      req.rx_length   <= '0;
      req.tx_ok       <= 1'b0;

      engine_cfg.dest_address    = DEST_ADDRESS_RST;
      engine_cfg.payload_length  = PAYLOAD_LENGTH_RST;
      engine_cfg.timeout_ticks   = TIMEOUT_TICKS_RST;
      engine_cfg.probe_kind_code = PROBE_KIND_CODE_RST;
      engine_cfg.reply_kind_code = REPLY_KIND_CODE_RST;
      engine_state = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_idle_events();
      test_reply_driven_run();
      test_timeout_run();
      test_random_runs();

      settle();
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      if (error_count == 0) begin
         $display("** link_rtt_probe_engine: PASSED **");
      end else begin
         $display("** link_rtt_probe_engine: FAILED **");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under a tenth of this.
   initial begin
      #4_000_000;
      $display("** link_rtt_probe_engine: FAILED **");
      $finish;
   end

endmodule

// ----- link_rtt_probe_engine.f -----
rtl/core/lrpe_pkg.sv
rtl/core/lrpe_req_if.sv
rtl/core/lrpe_rsp_if.sv
rtl/core/lrpe_step.sv
rtl/core/link_rtt_probe_engine.sv
tb/link_rtt_probe_engine_test.sv
